// ===== rtl/polygon_circle_overlap_test_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the polygon/circle overlap RTL
// ---------------------------------------------------------------------------
`ifndef POLYGON_CIRCLE_OVERLAP_TEST_MACROS_SVH
`define POLYGON_CIRCLE_OVERLAP_TEST_MACROS_SVH

// Same-cycle implication, disabled in reset
`define PCOT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcot assertion failed");

// Next-cycle implication, disabled in reset
`define PCOT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcot assertion failed");

`endif

// ===== rtl/pcot_pkg.sv =====
// ---------------------------------------------------------------------------
// pcot_pkg
// Types and constants of the polygon/circle overlap test.
// ---------------------------------------------------------------------------
package pcot_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int COORD_W      = 32;
    localparam int RAD_W        = 31;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int ACC_W        = PROD_W + 1;
    localparam int RR_W         = 2 * RAD_W;
    localparam int WIDE_W       = PROD_W;
    localparam int WIDE_P_W     = 2 * WIDE_W;
    localparam int DIG_W        = 11;
    localparam int N_DIG        = (WIDE_W + DIG_W - 1) / DIG_W;
    localparam int DIG_IDX_W    = $clog2(N_DIG);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic [IDX_W-1:0]           addr;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic [RAD_W-1:0]           r;
        logic [CNT_W-1:0]           cnt;
        logic                       ovf;
    } t_req;

endpackage

// ===== rtl/polygon_circle_overlap_test.sv =====
// ---------------------------------------------------------------------------
// polygon_circle_overlap_test
// Polygon store with exact circle overlap queries in Q16.16.
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy rises only
// when the two-entry request queue is full. Clear, append and unused commands
// give no result; each query gives one result strobe on o_result_valid, which
// must be taken in that cycle. The back end takes a request from the queue
// while idle; an append is written to the vertex store as it is taken. For a
// query the ray cast reads each edge of the polygon and does a cross-product
// compare for each edge that crosses the center line, then decides; an empty
// polygon reports from the idle state and a center found inside from the
// decide step. Otherwise the radius is squared and each edge is tested for
// distance, with two wide products for an edge whose nearest point lies
// inside the segment; the walk stops at the first edge in reach and the
// result strobe is registered. The sequence is set by the single shared
// 33x33 multiplier and the digit-serial wide multiplier that forms the two long products.
// ---------------------------------------------------------------------------
module polygon_circle_overlap_test (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_command,
    input  logic signed [pcot_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [pcot_pkg::COORD_W-1:0] i_point_y,
    input  logic [pcot_pkg::RAD_W-1:0]          i_radius,
    output logic                                o_result_valid,
    output logic                                o_collides,
    output logic                                o_center_inside,
    output logic                                o_overflowed
);
    import pcot_pkg::*;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_req q_push_req;
    t_req q_head;

    pcot_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_command  (i_command),
        .i_point_x  (i_point_x),
        .i_point_y  (i_point_y),
        .i_radius   (i_radius),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_push_req (q_push_req)
    );

    pcot_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_req (q_push_req),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_head     (q_head)
    );

    pcot_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (q_valid),
        .i_req           (q_head),
        .o_req_pop       (q_pop),
        .o_result_valid  (o_result_valid),
        .o_collides      (o_collides),
        .o_center_inside (o_center_inside),
        .o_overflowed    (o_overflowed)
    );

endmodule

// ===== rtl/pcot_front.sv =====
// ---------------------------------------------------------------------------
// pcot_front
// Accepts commands, tracks vertex count and overflow, forwards requests.
// ---------------------------------------------------------------------------
module pcot_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_command,
    input  logic signed [pcot_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [pcot_pkg::COORD_W-1:0] i_point_y,
    input  logic [pcot_pkg::RAD_W-1:0]        i_radius,
    input  logic                              i_full,
    output logic                              o_push,
    output pcot_pkg::t_req                    o_push_req
);
    import pcot_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic             accept;
    logic             has_room;

    // Stall the issuer while the queue is full
    assign busy     = i_full;
    assign accept   = start && !i_full;
    assign has_room = r_count < CNT_W'(MAX_VERTICES);

    // Classify the request
    always_comb begin
        o_push             = 1'b0;
        o_push_req.op      = OP_WRITE;
        o_push_req.addr    = r_count[IDX_W-1:0];
        o_push_req.x       = i_point_x;
        o_push_req.y       = i_point_y;
        o_push_req.r       = i_radius;
        o_push_req.cnt     = r_count;
        o_push_req.ovf     = r_ovf;
        unique case (t_cmd'(i_command))
            CMD_APPEND: begin
                o_push = accept && has_room;
            end
            CMD_QUERY: begin
                o_push        = accept;
                o_push_req.op = OP_QUERY;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    // Track polygon size and the sticky overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (accept) begin
            unique case (t_cmd'(i_command))
                CMD_CLEAR: begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
                CMD_APPEND: begin
                    if (has_room) begin
                        r_count <= r_count + CNT_W'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

endmodule

// ===== rtl/pcot_queue.sv =====
// ---------------------------------------------------------------------------
// pcot_queue
// Short request queue between front and back.
// ---------------------------------------------------------------------------
module pcot_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pcot_pkg::t_req i_push_req,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output pcot_pkg::t_req o_head
);
    import pcot_pkg::*;

    t_req              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QLVL_W-1:0] r_level;

    assign o_full  = r_level == QLVL_W'(QUEUE_DEPTH);
    assign o_valid = r_level != '0;
    assign o_head  = r_slot[r_rd];

    // Store requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_push_req;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + QLVL_W'(1);
            end else if (i_pop && !i_push) begin
                r_level <= r_level - QLVL_W'(1);
            end
        end
    end

endmodule

// ===== rtl/pcot_wmul.sv =====
// ---------------------------------------------------------------------------
// pcot_wmul
// Wide unsigned multiplier, one digit of the second operand per cycle.
// ---------------------------------------------------------------------------
module pcot_wmul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pcot_pkg::WIDE_W-1:0]    i_a,
    input  logic [pcot_pkg::WIDE_W-1:0]    i_b,
    output logic                           o_done,
    output logic [pcot_pkg::WIDE_P_W-1:0]  o_prod
);
    import pcot_pkg::*;

    localparam int PP_W  = WIDE_W + DIG_W;
    localparam int PAD_W = N_DIG * DIG_W;

    logic [WIDE_W-1:0]    r_a;
    logic [PAD_W-1:0]     r_b;
    logic [DIG_IDX_W-1:0] r_k;
    logic                 r_issue;
    logic                 r_pv;
    logic                 r_last;
    logic                 r_done;
    logic [PP_W-1:0]      r_pp;
    logic [WIDE_P_W-1:0]  r_acc;

    assign o_done = r_done;
    assign o_prod = r_acc;

    // Digits go most significant first so the accumulator shifts by a constant
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_pv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a     <= i_a;
                r_b     <= PAD_W'(i_b);
                r_k     <= DIG_IDX_W'(N_DIG - 1);
                r_issue <= 1'b1;
                r_pv    <= 1'b0;
                r_acc   <= '0;
            end else begin
                if (r_issue) begin
                    r_pp   <= PP_W'(r_a) * PP_W'(r_b[r_k*DIG_W +: DIG_W]);
                    r_pv   <= 1'b1;
                    r_last <= r_k == '0;
                    if (r_k == '0) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_k <= r_k - DIG_IDX_W'(1);
                    end
                end else begin
                    r_pv <= 1'b0;
                end
                if (r_pv) begin
                    r_acc  <= {r_acc[WIDE_P_W-DIG_W-1:0], DIG_W'(0)} + WIDE_P_W'(r_pp);
                    r_done <= r_last;
                end
            end
        end
    end

endmodule

// ===== rtl/pcot_back.sv =====
// ---------------------------------------------------------------------------
// pcot_back
// Holds the vertex store, runs the ray cast and the edge distance tests.
// ---------------------------------------------------------------------------
`include "polygon_circle_overlap_test_macros.svh"

module pcot_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  pcot_pkg::t_req i_req,
    output logic           o_req_pop,
    output logic           o_result_valid,
    output logic           o_collides,
    output logic           o_center_inside,
    output logic           o_overflowed
);
    import pcot_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_RRD, S_RM1, S_RM2, S_RCMP, S_RDONE, S_RSQ, S_RSQ2,
        S_DRD, S_D1, S_D2, S_D3, S_D4, S_D5, S_D6, S_D7, S_D8, S_D9,
        S_W1, S_W2
    } t_state;

    typedef enum logic [1:0] {
        M_NEAR_A, M_NEAR_B, M_PERP
    } t_mode;

    // Vertex store and its two registered read ports
    logic signed [COORD_W-1:0] r_mem_x [MAX_VERTICES];
    logic signed [COORD_W-1:0] r_mem_y [MAX_VERTICES];
    logic signed [COORD_W-1:0] r_ax, r_ay, r_bx, r_by;

    t_state                    r_state;
    t_mode                     r_mode;
    t_mode                     n_mode;
    logic [IDX_W-1:0]          r_i;
    logic [IDX_W-1:0]          r_j;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [COORD_W-1:0] r_cx, r_cy;
    logic [RAD_W-1:0]          r_r;
    logic                      r_ovf;
    logic                      r_inside;
    logic                      r_dpos;
    logic signed [PROD_W-1:0]  r_p;
    logic signed [PROD_W-1:0]  r_lhs;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   r_len;
    logic signed [ACC_W-1:0]   r_dot;
    logic [RR_W-1:0]           r_rr;
    logic [WIDE_P_W-1:0]       r_cc;
    logic                      r_wstart;
    logic [WIDE_W-1:0]         r_wa, r_wb;
    logic                      r_valid, r_collides, r_oinside, r_oovf;

    logic signed [DIFF_W-1:0]  dx, dy, ex, ey, fx, fy;
    logic signed [DIFF_W-1:0]  m_a, m_b;
    logic signed [ACC_W-1:0]   acc_mag;
    logic [IDX_W-1:0]          last_idx;
    logic [CNT_W:0]            i_plus2;
    logic                      dist_hit;
    logic                      w_done;
    logic [WIDE_P_W-1:0]       w_prod;

    assign o_req_pop       = (r_state == S_IDLE) && i_req_valid;
    assign o_result_valid  = r_valid;
    assign o_collides      = r_collides;
    assign o_center_inside = r_oinside;
    assign o_overflowed    = r_oovf;

    // Edge and center offsets
    assign dx       = DIFF_W'(r_bx) - DIFF_W'(r_ax);
    assign dy       = DIFF_W'(r_by) - DIFF_W'(r_ay);
    assign ex       = DIFF_W'(r_cx) - DIFF_W'(r_ax);
    assign ey       = DIFF_W'(r_cy) - DIFF_W'(r_ay);
    assign fx       = DIFF_W'(r_cx) - DIFF_W'(r_bx);
    assign fy       = DIFF_W'(r_cy) - DIFF_W'(r_by);
    assign acc_mag  = (r_acc < 0) ? -r_acc : r_acc;
    assign last_idx = IDX_W'(r_cnt - CNT_W'(1));
    assign i_plus2  = (CNT_W + 1)'(r_i) + (CNT_W + 1)'(2);
    assign dist_hit = $unsigned(r_acc) <= ACC_W'(r_rr);

    // Pick the nearest feature of the segment
    always_comb begin
        if (r_len == '0 || r_dot <= 0) begin
            n_mode = M_NEAR_A;
        end else if (r_dot >= r_len) begin
            n_mode = M_NEAR_B;
        end else begin
            n_mode = M_PERP;
        end
    end

    // Route operands to the shared multiplier
    always_comb begin
        m_a = dx;
        m_b = dx;
        case (r_state)
            S_RM1: begin m_a = ex; m_b = dy; end
            S_RM2: begin m_a = dx; m_b = ey; end
            S_RSQ: begin m_a = DIFF_W'(r_r); m_b = DIFF_W'(r_r); end
            S_D1:  begin m_a = dx; m_b = dx; end
            S_D2:  begin m_a = dy; m_b = dy; end
            S_D3:  begin m_a = ex; m_b = dx; end
            S_D4:  begin m_a = ey; m_b = dy; end
            S_D6: begin
                case (n_mode)
                    M_NEAR_A: begin m_a = ex; m_b = ex; end
                    M_NEAR_B: begin m_a = fx; m_b = fx; end
                    default:  begin m_a = ex; m_b = dy; end
                endcase
            end
            S_D7: begin
                case (r_mode)
                    M_NEAR_A: begin m_a = ey; m_b = ey; end
                    M_NEAR_B: begin m_a = fy; m_b = fy; end
                    default:  begin m_a = ey; m_b = dx; end
                endcase
            end
            default: begin m_a = dx; m_b = dx; end
        endcase
    end

    // Write and read the vertex store
    always_ff @(posedge i_clk) begin
        if (o_req_pop && i_req.op == OP_WRITE) begin
            r_mem_x[i_req.addr] <= i_req.x;
            r_mem_y[i_req.addr] <= i_req.y;
        end
        r_ax <= r_mem_x[r_i];
        r_ay <= r_mem_y[r_i];
        r_bx <= r_mem_x[r_j];
        r_by <= r_mem_y[r_j];
    end

    // Register every product
    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(m_a) * PROD_W'(m_b);
    end

    pcot_wmul u_wmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_wstart),
        .i_a     (r_wa),
        .i_b     (r_wb),
        .o_done  (w_done),
        .o_prod  (w_prod)
    );

    // Query sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_wstart <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
        end else begin
            r_valid  <= 1'b0;
            r_wstart <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid && i_req.op == OP_QUERY) begin
                        r_cx     <= i_req.x;
                        r_cy     <= i_req.y;
                        r_r      <= i_req.r;
                        r_cnt    <= i_req.cnt;
                        r_ovf    <= i_req.ovf;
                        r_inside <= 1'b0;
                        if (i_req.cnt == '0) begin
                            r_valid    <= 1'b1;
                            r_collides <= 1'b0;
                            r_oinside  <= 1'b0;
                            r_oovf     <= i_req.ovf;
                        end else begin
                            r_i     <= '0;
                            r_j     <= IDX_W'(i_req.cnt - CNT_W'(1));
                            r_state <= S_RRD;
                        end
                    end
                end
                S_RRD: begin
                    r_state <= S_RM1;
                end
                S_RM1: begin
                    r_dpos <= r_by > r_ay;
                    if ((r_ay > r_cy) != (r_by > r_cy)) begin
                        r_state <= S_RM2;
                    end else if (r_i == last_idx) begin
                        r_state <= S_RDONE;
                    end else begin
                        r_j     <= r_i;
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_RRD;
                    end
                end
                S_RM2: begin
                    r_lhs   <= r_p;
                    r_state <= S_RCMP;
                end
                S_RCMP: begin
                    // Toggle when the crossing lies right of the center
                    if (r_dpos ? (r_lhs < r_p) : (r_lhs > r_p)) begin
                        r_inside <= !r_inside;
                    end
                    if (r_i == last_idx) begin
                        r_state <= S_RDONE;
                    end else begin
                        r_j     <= r_i;
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_RRD;
                    end
                end
                S_RDONE: begin
                    if (r_inside) begin
                        r_valid    <= 1'b1;
                        r_collides <= 1'b1;
                        r_oinside  <= 1'b1;
                        r_oovf     <= r_ovf;
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_RSQ;
                    end
                end
                S_RSQ: begin
                    r_state <= S_RSQ2;
                end
                S_RSQ2: begin
                    r_rr    <= RR_W'(r_p);
                    r_i     <= '0;
                    r_j     <= (r_cnt == CNT_W'(1)) ? '0 : IDX_W'(1);
                    r_state <= S_DRD;
                end
                S_DRD: begin
                    r_state <= S_D1;
                end
                S_D1: begin
                    r_state <= S_D2;
                end
                S_D2: begin
                    r_acc   <= ACC_W'(r_p);
                    r_state <= S_D3;
                end
                S_D3: begin
                    r_len   <= r_acc + ACC_W'(r_p);
                    r_state <= S_D4;
                end
                S_D4: begin
                    r_acc   <= ACC_W'(r_p);
                    r_state <= S_D5;
                end
                S_D5: begin
                    r_dot   <= r_acc + ACC_W'(r_p);
                    r_state <= S_D6;
                end
                S_D6: begin
                    r_mode  <= n_mode;
                    r_state <= S_D7;
                end
                S_D7: begin
                    r_acc   <= ACC_W'(r_p);
                    r_state <= S_D8;
                end
                S_D8: begin
                    r_acc   <= (r_mode == M_PERP) ? r_acc - ACC_W'(r_p)
                                                  : r_acc + ACC_W'(r_p);
                    r_state <= S_D9;
                end
                S_D9: begin
                    if (r_mode == M_PERP) begin
                        r_wa     <= WIDE_W'(acc_mag);
                        r_wb     <= WIDE_W'(acc_mag);
                        r_wstart <= 1'b1;
                        r_state  <= S_W1;
                    end else if (dist_hit || r_i == last_idx) begin
                        r_valid    <= 1'b1;
                        r_collides <= dist_hit;
                        r_oinside  <= 1'b0;
                        r_oovf     <= r_ovf;
                        r_state    <= S_IDLE;
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_j     <= (i_plus2 < (CNT_W + 1)'(r_cnt)) ? IDX_W'(i_plus2) : '0;
                        r_state <= S_DRD;
                    end
                end
                S_W1: begin
                    if (w_done) begin
                        r_cc     <= w_prod;
                        r_wa     <= WIDE_W'(r_rr);
                        r_wb     <= WIDE_W'(r_len);
                        r_wstart <= 1'b1;
                        r_state  <= S_W2;
                    end
                end
                S_W2: begin
                    if (w_done) begin
                        if (r_cc <= w_prod || r_i == last_idx) begin
                            r_valid    <= 1'b1;
                            r_collides <= r_cc <= w_prod;
                            r_oinside  <= 1'b0;
                            r_oovf     <= r_ovf;
                            r_state    <= S_IDLE;
                        end else begin
                            r_i     <= r_i + IDX_W'(1);
                            r_j     <= (i_plus2 < (CNT_W + 1)'(r_cnt)) ? IDX_W'(i_plus2) : '0;
                            r_state <= S_DRD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `PCOT_ASSERT_IMP(a_inside_collides, i_clk, i_rst_n, r_valid && r_oinside, r_collides)
    `PCOT_ASSERT_IMP(a_empty_misses, i_clk, i_rst_n, r_valid && r_cnt == '0, !r_collides)
    `PCOT_ASSERT_IMP(a_wide_in_wait, i_clk, i_rst_n, w_done, r_state == S_W1 || r_state == S_W2)
    `PCOT_ASSERT_NXT(a_inside_reports, i_clk, i_rst_n, r_state == S_RDONE && r_inside, r_valid)

endmodule

// ===== test/overlap_checker.sv =====
// ---------------------------------------------------------------------------
// Overlap checker
// Watches the request and result ports of the polygon/circle overlap block,
// keeps its own copy of the polygon, predicts each query's answer with exact
// wide integer arithmetic and compares every result strobe in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module overlap_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_command,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic [30:0] i_radius,
    input  logic        i_result_valid,
    input  logic        i_collides,
    input  logic        i_center_inside,
    input  logic        i_overflowed,
    output int          o_errors,
    output int          o_pending,
    output int          o_queries
);
    import pcot_pkg::*;

    typedef struct packed {
        logic collides;
        logic ctr_in;
        logic ovf;
    } t_answer;

    // Polygon copy
    logic signed [63:0] poly_x [MAX_VERTICES];
    logic signed [63:0] poly_y [MAX_VERTICES];
    int                 poly_n;
    logic               poly_ovf;
    t_answer            answers_due [$];

    // Segment within radius of center, exact comparison on 200-bit values
    function automatic bit segment_near(int a, int b, logic signed [63:0] cx,
                                        logic signed [63:0] cy,
                                        logic signed [199:0] rr);
        logic signed [199:0] dx, dy, ex, ey, len, dot, crs;
        dx = poly_x[b] - poly_x[a];
        dy = poly_y[b] - poly_y[a];
        ex = cx - poly_x[a];
        ey = cy - poly_y[a];
        len = dx * dx + dy * dy;
        dot = ex * dx + ey * dy;
        if (len == 0 || dot <= 0)
            return (ex * ex + ey * ey) <= rr;
        if (dot >= len)
            return ((ex - dx) * (ex - dx) + (ey - dy) * (ey - dy)) <= rr;
        crs = ex * dy - ey * dx;
        return (crs * crs) <= rr * len;
    endfunction

    function automatic t_answer answer_query(logic signed [63:0] cx,
                                             logic signed [63:0] cy,
                                             logic [30:0] r);
        t_answer ans;
        logic signed [199:0] lhs, rhs, d, rr;
        int j;
        ans = '0;
        ans.ovf = poly_ovf;
        if (poly_n == 0) return ans;
        // Even-odd ray cast towards +x
        j = poly_n - 1;
        for (int i = 0; i < poly_n; i++) begin
            if ((poly_y[i] > cy) != (poly_y[j] > cy)) begin
                d = poly_y[j] - poly_y[i];
                lhs = (cx - poly_x[i]) * d;
                rhs = (poly_x[j] - poly_x[i]) * (cy - poly_y[i]);
                if (d > 0 ? lhs < rhs : lhs > rhs) ans.ctr_in = !ans.ctr_in;
            end
            j = i;
        end
        if (ans.ctr_in) begin
            ans.collides = 1'b1;
            return ans;
        end
        rr = $signed({169'd0, r}) * $signed({169'd0, r});
        for (int i = 0; i < poly_n && !ans.collides; i++)
            ans.collides = segment_near(i, (i + 1 < poly_n) ? i + 1 : 0, cx, cy, rr);
        return ans;
    endfunction

    // Track accepted requests and compare results
    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            poly_n   = 0;
            poly_ovf = 1'b0;
            answers_due.delete();
            o_errors  = 0;
            o_queries = 0;
        end else begin
            if (i_result_valid) begin
                if (answers_due.size() == 0) begin
                    $error("result with no query waiting");
                    o_errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (want.collides !== i_collides) begin
                        $error("collides: expected %0d got %0d", want.collides, i_collides);
                        o_errors++;
                    end
                    if (want.ctr_in !== i_center_inside) begin
                        $error("center_inside: expected %0d got %0d",
                               want.ctr_in, i_center_inside);
                        o_errors++;
                    end
                    if (want.ovf !== i_overflowed) begin
                        $error("overflowed: expected %0d got %0d", want.ovf, i_overflowed);
                        o_errors++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                case (i_command)
                    CMD_CLEAR: begin
                        poly_n   = 0;
                        poly_ovf = 1'b0;
                    end
                    CMD_APPEND: begin
                        if (poly_n < MAX_VERTICES) begin
                            poly_x[poly_n] = i_point_x;
                            poly_y[poly_n] = i_point_y;
                            poly_n++;
                        end else begin
                            poly_ovf = 1'b1;
                        end
                    end
                    CMD_QUERY: begin
                        answers_due = {answers_due,
                                       answer_query(i_point_x, i_point_y, i_radius)};
                        o_queries++;
                    end
                    default: ;
                endcase
            end
        end
        o_pending = answers_due.size();
    end
endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// Polygon/circle overlap testbench
// Builds polygons from clears and appends, fires directed and random circle
// queries with random request gaps, and leaves checking to overlap_checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import pcot_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;

    logic        clk, rst_n, start, busy;
    logic [1:0]  command;
    logic signed [31:0] point_x, point_y;
    logic [30:0] radius;
    logic        result_valid, collides, center_inside, overflowed;
    int          errors, pending, queries, gap_pct, cycles, requests;

    polygon_circle_overlap_test i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy),
        .i_command(command), .i_point_x(point_x), .i_point_y(point_y),
        .i_radius(radius), .o_result_valid(result_valid), .o_collides(collides),
        .o_center_inside(center_inside), .o_overflowed(overflowed)
    );

    overlap_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_command(command), .i_point_x(point_x), .i_point_y(point_y),
        .i_radius(radius), .i_result_valid(result_valid), .i_collides(collides),
        .i_center_inside(center_inside), .i_overflowed(overflowed),
        .o_errors(errors), .o_pending(pending), .o_queries(queries)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Issue one request and hold it until taken; start stays high for the next one
    task automatic send(input t_cmd cmd, input logic signed [31:0] x,
                        input logic signed [31:0] y, input logic [30:0] r);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        point_x <= x;
        point_y <= y;
        radius  <= r;
        do @(posedge clk); while (busy);
        requests++;
        @(negedge clk);
    endtask

    // Coordinates mostly in a small window so shapes actually meet circles
    function automatic logic signed [31:0] coord();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(40 << 16)) - (20 << 16);
        endcase
    endfunction

    function automatic logic [30:0] rad();
        case ($urandom_range(9))
            0:       return 31'($urandom);
            1:       return $urandom_range(1) ? 31'h7fffffff : 31'd0;
            default: return 31'($urandom_range(12 << 16));
        endcase
    endfunction

    task automatic random_phase(input int pct, input int n);
        int nv;
        gap_pct = pct;
        for (int k = 0; k < n; k++) begin
            // Well-formed polygon then several queries; sometimes noise
            if ($urandom_range(9) == 0) begin
                send(t_cmd'($urandom_range(3)), $urandom, $urandom, 31'($urandom));
            end else begin
                send(CMD_CLEAR, $urandom, $urandom, 31'($urandom));
                nv = ($urandom_range(7) == 0) ? $urandom_range(17, 19) : $urandom_range(0, 8);
                for (int v = 0; v < nv; v++)
                    send(CMD_APPEND, coord(), coord(), 31'($urandom));
                for (int q = $urandom_range(1, 4); q > 0; q--)
                    send(CMD_QUERY, coord(), coord(), rad());
            end
        end
    endtask

    initial begin
        start = 1'b0; command = CMD_CLEAR; point_x = '0; point_y = '0; radius = '0;
        rst_n = 1'b0; gap_pct = 0; requests = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty polygon, unit square, edges, corners, degenerate shapes, overflow
        send(CMD_QUERY, 0, 0, 31'h7fffffff);
        send(CMD_APPEND, 0, 0, 0);
        send(CMD_APPEND, 32'sh10000, 0, 0);
        send(CMD_APPEND, 32'sh10000, 32'sh10000, 0);
        send(CMD_APPEND, 0, 32'sh10000, 0);
        send(CMD_QUERY, 32'sh8000, 32'sh8000, 0);
        send(CMD_QUERY, 32'sh20000, 32'sh8000, 31'h10000);
        send(CMD_QUERY, 32'sh20000, 32'sh8000, 31'hffff);
        send(CMD_QUERY, 32'sh20000, 32'sh20000, 31'h16a09);
        send(CMD_QUERY, 32'sh80000000, 32'sh7fffffff, 31'h7fffffff);
        send(CMD_RSVD, 1, 1, 1);
        send(CMD_CLEAR, 0, 0, 0);
        send(CMD_APPEND, 32'sh7fffffff, 32'sh7fffffff, 0);
        send(CMD_APPEND, 32'sh7fffffff, 32'sh7fffffff, 0);
        send(CMD_QUERY, 32'sh80000000, 32'sh80000000, 31'h7fffffff);
        send(CMD_QUERY, 32'sh7fffffff, 32'sh7fffffff, 0);
        send(CMD_CLEAR, 0, 0, 0);
        for (int v = 0; v < 17; v++) send(CMD_APPEND, v << 16, (v & 1) << 18, 0);
        send(CMD_QUERY, 32'sh30000, 32'sh10000, 0);

        // Random: light sender gaps, heavy gaps, then none
        random_phase(30, 60);
        random_phase(50, 60);
        random_phase(0, 50);
        start <= 1'b0;

        // Drain results, then allow for trailing work
        while (pending != 0) @(posedge clk);
        repeat (1500) @(posedge clk);
        $display("covered %0d requests, %0d queries checked against exact geometry",
                 requests, queries);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ===== polygon_circle_overlap_test.f =====
+incdir+rtl
rtl/pcot_pkg.sv
rtl/pcot_front.sv
rtl/pcot_queue.sv
rtl/pcot_wmul.sv
rtl/pcot_back.sv
rtl/polygon_circle_overlap_test.sv
test/overlap_checker.sv
test/testbench.sv
